// File: hdl/assert_macros.svh
// Assertion macros shared by the page allocator modules.
// Define ASSERT_OFF to compile them out; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_ALWAYS(label, clk, rst_n, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("assertion failed");

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define ASSERT_ALWAYS(label, clk, rst_n, expr)
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// File: hdl/pgalloc_pkg.sv
// Shared types and constants for the page allocator.
// Used by pgalloc_ctrl, pgalloc_datapath and page_allocator_with_handles.
package pgalloc_pkg;

  localparam int NUM_PAGES   = 16;
  localparam int PAGE_BYTES  = 4;
  localparam int NUM_HANDLES = 16;
  localparam int MAX_RESULTS = 16;

  localparam int PAGE_W   = $clog2(NUM_PAGES);
  localparam int HANDLE_W = $clog2(NUM_HANDLES);
  localparam int CNT_W    = $clog2(NUM_PAGES + 1);
  localparam int NEED_W   = 9;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_NO_PAGES   = 2'd1,
    ST_NO_HANDLE  = 2'd2,
    ST_BAD_HANDLE = 2'd3
  } status_t;

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } command_t;

  typedef struct packed {
    logic       command;
    logic [7:0] request_bytes;
    logic [3:0] handle_in;
  } in_req_t;

  typedef struct packed {
    logic [1:0] status;
    logic [3:0] handle_out;
    logic [3:0] page_index;
    logic       last;
  } out_res_t;

  typedef struct packed {
    logic    load;
    logic    grab;
    logic    alloc_step;
    logic    free_step;
    logic    release_handle;
    logic    emit;
    status_t emit_st;
  } dp_cmd_t;

  typedef struct packed {
    logic is_free;
    logic need_ok;
    logic handle_avail;
    logic target_used;
    logic alloc_final;
    logic scan_end;
    logic out_room;
  } dp_stat_t;

endpackage

// File: hdl/pgalloc_ctrl.sv
// Sequencer for allocate and free requests.
// Depends on pgalloc_pkg; drives pgalloc_datapath through dp_cmd_t.
`include "assert_macros.svh"

module pgalloc_ctrl
  import pgalloc_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_ALLOC,
    S_FREE,
    S_FREE_DONE
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.emit_st = ST_OK;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (stat.is_free) begin
          if (stat.target_used) begin
            state_nxt = S_FREE;
          end else if (stat.out_room) begin
            cmd.emit    = 1'b1;
            cmd.emit_st = ST_BAD_HANDLE;
            state_nxt   = S_IDLE;
          end
        end else if (!stat.need_ok) begin
          if (stat.out_room) begin
            cmd.emit    = 1'b1;
            cmd.emit_st = ST_NO_PAGES;
            state_nxt   = S_IDLE;
          end
        end else if (!stat.handle_avail) begin
          if (stat.out_room) begin
            cmd.emit    = 1'b1;
            cmd.emit_st = ST_NO_HANDLE;
            state_nxt   = S_IDLE;
          end
        end else begin
          cmd.grab  = 1'b1;
          state_nxt = S_ALLOC;
        end
      end
      S_ALLOC: begin
        if (stat.out_room) begin
          cmd.alloc_step = 1'b1;
          if (stat.alloc_final) begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_FREE: begin
        cmd.free_step = 1'b1;
        if (stat.scan_end) begin
          state_nxt = S_FREE_DONE;
        end
      end
      S_FREE_DONE: begin
        if (stat.out_room) begin
          cmd.emit           = 1'b1;
          cmd.emit_st        = ST_OK;
          cmd.release_handle = 1'b1;
          state_nxt          = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  `ASSERT_IMPLIES(a_alloc_needs_room, clk, rst_n, cmd.alloc_step, stat.out_room)
  `ASSERT_NEXT(a_final_ends_alloc, clk, rst_n,
               state_r == S_ALLOC && cmd.alloc_step && stat.alloc_final, state_r == S_IDLE)
  `ASSERT_IMPLIES(a_grab_has_handle, clk, rst_n, cmd.grab,
                  stat.handle_avail && stat.need_ok && !stat.is_free)

endmodule

// File: hdl/pgalloc_datapath.sv
// Page and handle tables, scan counters and result register.
// Depends on pgalloc_pkg; commanded by pgalloc_ctrl.
`include "assert_macros.svh"

module pgalloc_datapath
  import pgalloc_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  in_req_t  in_req,
  input  dp_cmd_t  cmd,
  output dp_stat_t stat,
  output logic     out_valid,
  input  logic     out_ready,
  output out_res_t out_res
);

  logic [NUM_PAGES-1:0]   page_used_r;
  logic [NUM_HANDLES-1:0] handle_used_r;
  logic [HANDLE_W-1:0]    page_owner_r [NUM_PAGES];
  logic [CNT_W-1:0]       free_cnt_r;
  logic                   out_valid_r;
  out_res_t               out_r;
  logic                   is_free_r;
  logic [NEED_W-1:0]      need_r;
  logic [HANDLE_W-1:0]    handle_r;
  logic [PAGE_W-1:0]      idx_r;
  logic [CNT_W-1:0]       got_r;

  logic [HANDLE_W-1:0]    pick;
  logic                   hit;
  logic                   owned;
  logic                   final_hit;

  always_comb begin
    pick = '0;
    for (int h = NUM_HANDLES - 1; h >= 0; h--) begin
      if (!handle_used_r[h]) begin
        pick = HANDLE_W'(h);
      end
    end
  end

  assign hit       = !page_used_r[idx_r];
  assign owned     = page_used_r[idx_r] && (page_owner_r[idx_r] == handle_r);
  assign final_hit = hit && ((NEED_W'(got_r) + NEED_W'(1)) == need_r);

  assign stat.is_free      = is_free_r;
  assign stat.need_ok      = (need_r <= NEED_W'(free_cnt_r)) &&
                             (need_r <= NEED_W'(MAX_RESULTS));
  assign stat.handle_avail = !(&handle_used_r);
  assign stat.target_used  = handle_used_r[handle_r];
  assign stat.alloc_final  = final_hit;
  assign stat.scan_end     = (idx_r == PAGE_W'(NUM_PAGES - 1));
  assign stat.out_room     = !out_valid_r || out_ready;

  assign out_valid = out_valid_r;
  assign out_res   = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      page_used_r   <= '0;
      handle_used_r <= '0;
      free_cnt_r    <= CNT_W'(NUM_PAGES);
      out_valid_r   <= 1'b0;
    end else begin
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cmd.grab) begin
        handle_used_r[pick] <= 1'b1;
      end
      if (cmd.release_handle) begin
        handle_used_r[handle_r] <= 1'b0;
      end
      if (cmd.alloc_step && hit) begin
        page_used_r[idx_r] <= 1'b1;
        free_cnt_r         <= free_cnt_r - CNT_W'(1);
        out_valid_r        <= 1'b1;
      end
      if (cmd.free_step && owned) begin
        page_used_r[idx_r] <= 1'b0;
        free_cnt_r         <= free_cnt_r + CNT_W'(1);
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      is_free_r <= in_req.command;
      need_r    <= NEED_W'(in_req.request_bytes / PAGE_BYTES) + NEED_W'(1);
      handle_r  <= HANDLE_W'(in_req.handle_in);
      idx_r     <= '0;
      got_r     <= '0;
    end
    if (cmd.grab) begin
      handle_r <= pick;
    end
    if (cmd.alloc_step || cmd.free_step) begin
      idx_r <= idx_r + PAGE_W'(1);
    end
    if (cmd.alloc_step && hit) begin
      page_owner_r[idx_r] <= handle_r;
      got_r               <= got_r + CNT_W'(1);
      out_r.status        <= ST_OK;
      out_r.handle_out    <= 4'(handle_r);
      out_r.page_index    <= 4'(idx_r);
      out_r.last          <= final_hit;
    end
    if (cmd.emit) begin
      out_r.status     <= cmd.emit_st;
      out_r.handle_out <= (cmd.emit_st == ST_OK || cmd.emit_st == ST_BAD_HANDLE) ?
                          4'(handle_r) : 4'd0;
      out_r.page_index <= 4'd0;
      out_r.last       <= 1'b1;
    end
  end

  `ASSERT_ALWAYS(a_free_count, clk, rst_n,
                 free_cnt_r == CNT_W'($countones(~page_used_r)))
  `ASSERT_IMPLIES(a_grab_free_handle, clk, rst_n, cmd.grab, !handle_used_r[pick])
  `ASSERT_IMPLIES(a_release_busy, clk, rst_n, cmd.release_handle, handle_used_r[handle_r])
  `ASSERT_IMPLIES(a_single_emit, clk, rst_n, cmd.emit, !(cmd.alloc_step && hit))

endmodule

// File: hdl/page_allocator_with_handles.sv
// Top level of the page allocator: joins controller and datapath.
// Depends on pgalloc_pkg, pgalloc_ctrl and pgalloc_datapath.
//
//   channel | ports                         | payload
//   in      | in_valid, in_ready, in_req    | in_req_t: command, request_bytes, handle_in
//   out     | out_valid, out_ready, out_res | out_res_t: status, handle_out, page_index, last
//
// One request at a time: an accept state and a decide state, then the scan.
// Allocate emits one result per page it takes and ends on its last page.
// Free scans all NUM_PAGES pages and emits one result after.
// Failures answer from the decide state. A stalled output register holds the allocate
// scan and every pending result. Reset (rst_n low, synchronous) marks every page and
// handle free at once.
module page_allocator_with_handles
  import pgalloc_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_req_t  in_req,
  output logic     out_valid,
  input  logic     out_ready,
  output out_res_t out_res
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  pgalloc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  pgalloc_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (in_req),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

endmodule
